// File: sv/bta_pkg.sv
// Shared types and constants for the boundary-tag first-fit allocator.
// No dependencies; imported by every module of the block except the tag store.
package bta_pkg;

   // Fixed field widths of the request and response channels
   localparam int BYTES_W = 17;
   localparam int UNIT_W  = 12;
   // Width of a needed-unit count over the full byte field:
   // ceil((2^17 - 1)/16) + 2 = 8194
   localparam int NEED_W  = 14;

   // Request operation codes
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // Controller sequencer states
   typedef enum logic [3:0] {
      ST_INIT_HEAD,
      ST_INIT_FOOT,
      ST_IDLE,
      ST_WALK,
      ST_FREE_HEAD,
      ST_FREE_NEXT,
      ST_FREE_PFOOT,
      ST_FREE_PREV,
      ST_FREE_FIN,
      ST_WRITE,
      ST_RESULT
   } state_type;

   // Finished result handed from the controller to the response register
   typedef struct packed {
      logic              valid;
      logic [UNIT_W-1:0] unit;
      logic              ok;
   } res_type;

endpackage

// File: sv/bta_tag_ram.sv
// Tag store: one write port, one read port, registered read data.
// No package dependencies.
module bta_tag_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 14
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bta_ctrl.sv
// Allocator sequencer: first-fit walk, coalescing free, tag write-back.
// Depends on bta_pkg; drives the ports of bta_tag_ram.
module bta_ctrl #(
   parameter int ARENA_UNITS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [bta_pkg::BYTES_W-1:0]          req_request_bytes,
   input  logic [bta_pkg::UNIT_W-1:0]           req_payload_unit,
   output logic                                 wr_en,
   output logic [$clog2(ARENA_UNITS)-1:0]       wr_addr,
   output logic [$clog2(ARENA_UNITS+1):0]       wr_data,
   output logic                                 rd_en,
   output logic [$clog2(ARENA_UNITS)-1:0]       rd_addr,
   input  logic [$clog2(ARENA_UNITS+1):0]       rd_data,
   output bta_pkg::res_type                     res,
   input  logic                                 res_ready
);

   import bta_pkg::*;

   localparam int AW = $clog2(ARENA_UNITS);
   localparam int SW = $clog2(ARENA_UNITS + 1);
   localparam int XW = (SW + 2 > 14) ? SW + 2 : 14;
   localparam logic [XW-1:0] ARENA_X = XW'(ARENA_UNITS);
   localparam logic [SW-1:0] ARENA_S = SW'(ARENA_UNITS);
   localparam logic [AW-1:0] LAST_A  = AW'(ARENA_UNITS - 1);

   state_type           state_ff, state_in;
   logic [SW-1:0]       b_ff, b_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [AW-1:0]       h_ff, h_in;
   logic [AW-1:0]       p_ff, p_in;
   logic [AW-1:0]       lo_ff, lo_in;
   logic [XW-1:0]       total_ff, total_in;
   logic [AW-1:0]       head_a_ff, head_a_in;
   logic [SW-1:0]       size_a_ff, size_a_in;
   logic                used_a_ff, used_a_in;
   logic                foot_en_ff, foot_en_in;
   logic [AW-1:0]       head_b_ff, head_b_in;
   logic [SW-1:0]       size_b_ff, size_b_in;
   logic                two_ff, two_in;
   logic [1:0]          wcnt_ff, wcnt_in;
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic                ok_ff, ok_in;

   logic [SW-1:0]       rd_size;
   logic                rd_used;
   logic [XW-1:0]       sx, bx, hx, nx, lox, room, rem, nb;
   logic [BYTES_W:0]    bytes_up;
   logic [UNIT_W-1:0]   h_raw;
   logic [AW-1:0]       foot_a, foot_b;
   logic                last_wr;

   assign rd_size = rd_data[SW:1];
   assign rd_used = rd_data[0];
   assign sx      = XW'(rd_size);
   assign bx      = XW'(b_ff);
   assign hx      = XW'(h_ff);
   assign nx      = XW'(need_ff);
   assign lox     = XW'(lo_ff);
   assign rem     = sx - nx;
   assign nb      = bx + sx;
   assign room    = ARENA_X - lox;

   assign bytes_up = {1'b0, req_request_bytes} + (BYTES_W + 1)'(15);
   assign h_raw    = req_payload_unit - UNIT_W'(1);

   assign foot_a  = AW'(XW'(head_a_ff) + XW'(size_a_ff) - XW'(1));
   assign foot_b  = AW'(XW'(head_b_ff) + XW'(size_b_ff) - XW'(1));
   assign last_wr = two_ff ? (wcnt_ff == 2'd3) : (wcnt_ff == 2'd1);

   assign res.valid = (state_ff == ST_RESULT);
   assign res.unit  = unit_ff;
   assign res.ok    = ok_ff;

   // Hold state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_HEAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold working registers
   always_ff @(posedge clock) begin
      b_ff       <= b_in;
      need_ff    <= need_in;
      h_ff       <= h_in;
      p_ff       <= p_in;
      lo_ff      <= lo_in;
      total_ff   <= total_in;
      head_a_ff  <= head_a_in;
      size_a_ff  <= size_a_in;
      used_a_ff  <= used_a_in;
      foot_en_ff <= foot_en_in;
      head_b_ff  <= head_b_in;
      size_b_ff  <= size_b_in;
      two_ff     <= two_in;
      wcnt_ff    <= wcnt_in;
      unit_ff    <= unit_in;
      ok_ff      <= ok_in;
   end

   // Next state, memory requests and register updates
   always_comb begin
      state_in   = state_ff;
      b_in       = b_ff;
      need_in    = need_ff;
      h_in       = h_ff;
      p_in       = p_ff;
      lo_in      = lo_ff;
      total_in   = total_ff;
      head_a_in  = head_a_ff;
      size_a_in  = size_a_ff;
      used_a_in  = used_a_ff;
      foot_en_in = foot_en_ff;
      head_b_in  = head_b_ff;
      size_b_in  = size_b_ff;
      two_in     = two_ff;
      wcnt_in    = wcnt_ff;
      unit_in    = unit_ff;
      ok_in      = ok_ff;
      req_ready  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;

      unique case (state_ff)
         // Lay down the single free block that spans the arena
         ST_INIT_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {ARENA_S, 1'b0};
            state_in = ST_INIT_FOOT;
         end
         ST_INIT_FOOT: begin
            wr_en    = 1'b1;
            wr_addr  = LAST_A;
            wr_data  = {ARENA_S, 1'b0};
            state_in = ST_IDLE;
         end
         // Take a request and start its first read
         ST_IDLE: begin
            req_ready = 1'b1;
            unit_in   = '0;
            ok_in     = 1'b0;
            if (req_valid) begin
               if (op_type'(req_operation) == OP_ALLOC) begin
                  need_in = NEED_W'(bytes_up >> 4) + NEED_W'(2);
                  b_in    = '0;
                  if (req_request_bytes == '0) begin
                     state_in = ST_RESULT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_WALK;
                  end
               end else begin
                  h_in = AW'(h_raw);
                  if (req_payload_unit == '0 || XW'(h_raw) >= ARENA_X) begin
                     state_in = ST_RESULT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(h_raw);
                     state_in = ST_FREE_HEAD;
                  end
               end
            end
         end
         // Examine one block header per cycle, prefetching the next one
         ST_WALK: begin
            if (sx < XW'(2) || sx > ARENA_X - bx) begin
               state_in = ST_RESULT;
            end else if (!rd_used && sx >= nx) begin
               head_a_in  = AW'(b_ff);
               used_a_in  = 1'b1;
               foot_en_in = 1'b1;
               wcnt_in    = '0;
               unit_in    = UNIT_W'(bx + XW'(1));
               ok_in      = 1'b1;
               if (rem >= XW'(2)) begin
                  size_a_in = SW'(need_ff);
                  head_b_in = AW'(bx + nx);
                  size_b_in = SW'(rem);
                  two_in    = 1'b1;
               end else begin
                  size_a_in = rd_size;
                  two_in    = 1'b0;
               end
               state_in = ST_WRITE;
            end else if (nb == ARENA_X) begin
               state_in = ST_RESULT;
            end else begin
               b_in    = SW'(nb);
               rd_en   = 1'b1;
               rd_addr = AW'(nb);
            end
         end
         // Freed block header: size and next-block read
         ST_FREE_HEAD: begin
            total_in = sx;
            lo_in    = h_ff;
            if (rd_size != '0 && sx < ARENA_X - hx) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(hx + sx);
               state_in = ST_FREE_NEXT;
            end else if (h_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = h_ff - AW'(1);
               state_in = ST_FREE_PFOOT;
            end else begin
               state_in = ST_FREE_FIN;
            end
         end
         // Absorb a free next block
         ST_FREE_NEXT: begin
            if (!rd_used) begin
               total_in = total_ff + sx;
            end
            if (h_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = h_ff - AW'(1);
               state_in = ST_FREE_PFOOT;
            end else begin
               state_in = ST_FREE_FIN;
            end
         end
         // Previous footer locates the previous header
         ST_FREE_PFOOT: begin
            if (rd_size != '0 && sx <= hx) begin
               p_in     = AW'(hx - sx);
               rd_en    = 1'b1;
               rd_addr  = AW'(hx - sx);
               state_in = ST_FREE_PREV;
            end else begin
               state_in = ST_FREE_FIN;
            end
         end
         // Absorb a free previous block
         ST_FREE_PREV: begin
            if (!rd_used) begin
               lo_in    = p_ff;
               total_in = total_ff + sx;
            end
            state_in = ST_FREE_FIN;
         end
         // Clip the merged block at the arena end and set up its tags
         ST_FREE_FIN: begin
            head_a_in  = lo_ff;
            size_a_in  = (total_ff > room) ? SW'(room) : SW'(total_ff);
            foot_en_in = (total_ff > room) ? (room != '0) : (total_ff != '0);
            used_a_in  = 1'b0;
            two_in     = 1'b0;
            wcnt_in    = '0;
            unit_in    = '0;
            ok_in      = 1'b1;
            state_in   = ST_WRITE;
         end
         // Write back header and footer tags, one per cycle
         ST_WRITE: begin
            wr_en   = 1'b1;
            wcnt_in = wcnt_ff + 2'd1;
            case (wcnt_ff)
               2'd0: begin
                  wr_addr = head_a_ff;
                  wr_data = {size_a_ff, used_a_ff};
               end
               2'd1: begin
                  wr_addr = foot_en_ff ? foot_a : head_a_ff;
                  wr_data = {size_a_ff, used_a_ff};
               end
               2'd2: begin
                  wr_addr = head_b_ff;
                  wr_data = {size_b_ff, 1'b0};
               end
               default: begin
                  wr_addr = foot_b;
                  wr_data = {size_b_ff, 1'b0};
               end
            endcase
            if (last_wr) begin
               state_in = ST_RESULT;
            end
         end
         // Hand the result over once the response register has room
         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit allocator with response register.
// Depends on bta_pkg, bta_tag_ram and bta_ctrl.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | operation, request_bytes, payload_unit
//   rsp     | out       | rsp_valid/rsp_ready  | granted_unit, success
//
// One item at a time. Allocate: intake cycle, one cycle per block walked,
// 2 or 4 tag writes when granted (one write port), then the result cycle.
// Free: intake, header reads and merging on the single read port, 2 tag writes,
// then the result cycle. Null requests go from intake straight to the result.
// After reset, ST_INIT_HEAD and ST_INIT_FOOT lay down the arena block; req_ready stays low.
// A held response does not block intake; a second result waits in the
// controller until the response register drains.
module boundary_tag_first_fit_allocator #(
   parameter int ARENA_UNITS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [bta_pkg::BYTES_W-1:0]  req_request_bytes,
   input  logic [bta_pkg::UNIT_W-1:0]   req_payload_unit,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bta_pkg::UNIT_W-1:0]   rsp_granted_unit,
   output logic                         rsp_success
);

   import bta_pkg::*;

   localparam int AW = $clog2(ARENA_UNITS);
   localparam int TW = $clog2(ARENA_UNITS + 1) + 1;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [TW-1:0]     wr_data, rd_data;
   res_type           res;
   logic              res_ready;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              ok_ff, ok_in;

   bta_tag_ram #(
      .DEPTH (ARENA_UNITS),
      .WIDTH (TW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bta_ctrl #(
      .ARENA_UNITS (ARENA_UNITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_request_bytes (req_request_bytes),
      .req_payload_unit  (req_payload_unit),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .res               (res),
      .res_ready         (res_ready)
   );

   // Load the response register when empty or draining
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      unit_in      = unit_ff;
      ok_in        = ok_ff;
      if (res.valid && res_ready) begin
         rsp_valid_in = 1'b1;
         unit_in      = res.unit;
         ok_in        = res.ok;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      ok_ff   <= ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_unit = unit_ff;
   assign rsp_success      = ok_ff;

endmodule

// File: sv/bta_checker.sv
// Port-level checks for the boundary-tag first-fit allocator, with bind.
// Depends on bta_pkg and boundary_tag_first_fit_allocator.
module bta_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bta_pkg::UNIT_W-1:0]   rsp_granted_unit,
   input logic                         rsp_success
);

   import bta_pkg::*;

   // Stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_unit)
                                  && $stable(rsp_success))
      else $error("response changed while stalled");

   // A granted unit only comes with success
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_unit != '0 |-> rsp_success)
      else $error("granted unit without success");

   // Intake closes after each transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Arena setup blocks intake right after reset
   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("ready during arena setup");

   // A new response follows a busy cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without work in progress");

endmodule

bind boundary_tag_first_fit_allocator bta_checker u_bta_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the boundary-tag first-fit allocator.
// Depends on bta_pkg and boundary_tag_first_fit_allocator; keeps its own tag-store shadow.
`timescale 1ns / 1ps

module testbench;
   import bta_pkg::*;

   localparam int ARENA_UNITS      = 4096;
   localparam int MAX_BYTES        = 65536;
   localparam int FIELD_MAX_BYTES  = (1 << BYTES_W) - 1;
   localparam int RANDOM_ITEMS     = 1700;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int DRAIN_CYCLES     = 40;

   // One expected response
   typedef struct {
      logic [UNIT_W-1:0] unit;
      logic              ok;
   } grant_expect_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [BYTES_W-1:0]  req_request_bytes;
   logic [UNIT_W-1:0]   req_payload_unit;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [UNIT_W-1:0]   rsp_granted_unit;
   logic                rsp_success;

   // Shadow of the tag store: {size, in_use} per unit
   logic [13:0]         tag_shadow [0:ARENA_UNITS-1];
   grant_expect_type    pending_grants [$];
   logic [UNIT_W-1:0]   live_units [$];

   int                  errors = 0;
   int                  quiet_cycles = 0;
   int                  n_alloc = 0;
   int                  n_granted = 0;
   int                  n_release = 0;
   int                  n_released = 0;
   int                  n_checked = 0;
   bit                  idle_on = 1'b1;
   bit                  long_hold_req = 1'b0;
   int                  long_holds_done = 0;

   boundary_tag_first_fit_allocator #(
      .ARENA_UNITS(ARENA_UNITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_request_bytes (req_request_bytes),
      .req_payload_unit  (req_payload_unit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_unit  (rsp_granted_unit),
      .rsp_success       (rsp_success)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Allocator shadow
   // ---------------------------------------------------------------
   function automatic int unsigned tag_len(int unsigned u);
      return int'(tag_shadow[u][13:1]);
   endfunction

   function automatic bit tag_busy(int unsigned u);
      return tag_shadow[u][0];
   endfunction

   // Write header and, when it fits, footer of one block
   function automatic void put_shadow_tags(int unsigned head, int unsigned size, bit busy);
      logic [13:0] word;
      if (head >= ARENA_UNITS) return;
      word = {size[12:0], busy};
      tag_shadow[head] = word;
      if (size >= 1 && size - 1 < ARENA_UNITS - head)
         tag_shadow[head + size - 1] = word;
   endfunction

   function automatic void clear_shadow();
      foreach (tag_shadow[i]) tag_shadow[i] = '0;
      put_shadow_tags(0, ARENA_UNITS, 1'b0);
   endfunction

   // First-fit walk with split; returns the granted payload unit or 0
   function automatic logic [UNIT_W-1:0] predict_alloc(int unsigned nbytes);
      int unsigned need, b, s, rest;
      if (nbytes == 0) return '0;
      need = (nbytes + 15) / 16 + 2;
      b = 0;
      while (b < ARENA_UNITS) begin
         s = tag_len(b);
         if (s < 2 || s > ARENA_UNITS - b) break;
         if (!tag_busy(b) && s >= need) begin
            rest = s - need;
            if (rest >= 2) begin
               put_shadow_tags(b, need, 1'b1);
               put_shadow_tags(b + need, rest, 1'b0);
            end else begin
               put_shadow_tags(b, s, 1'b1);
            end
            return UNIT_W'(b + 1);
         end
         b += s;
      end
      return '0;
   endfunction

   // Mark free and coalesce with free neighbors; returns 1 when performed
   function automatic bit predict_release(int unsigned pu);
      int unsigned h, lo, s, total, ps;
      if (pu == 0) return 1'b0;
      h = pu - 1;
      if (h >= ARENA_UNITS) return 1'b0;
      s = tag_len(h);
      total = s;
      lo = h;
      if (s >= 1 && s < ARENA_UNITS - h) begin
         if (!tag_busy(h + s)) total += tag_len(h + s);
      end
      if (h > 0) begin
         ps = tag_len(h - 1);
         if (ps >= 1 && ps <= h) begin
            if (!tag_busy(h - ps)) begin
               lo = h - ps;
               total += tag_len(lo);
            end
         end
      end
      if (total > ARENA_UNITS - lo) total = ARENA_UNITS - lo;
      put_shadow_tags(lo, total, 1'b0);
      return 1'b1;
   endfunction

   // Payload unit of a random block that is currently free, or 0
   function automatic int unsigned pick_free_block();
      int unsigned b, s;
      int unsigned heads [$];
      b = 0;
      while (b < ARENA_UNITS) begin
         s = tag_len(b);
         if (s < 2 || s > ARENA_UNITS - b) break;
         if (!tag_busy(b)) heads.push_back(b + 1);
         b += s;
      end
      if (heads.size() == 0) return 0;
      return heads[$urandom_range(0, heads.size() - 1)];
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   // Offer one item, wait for its transfer, then record the expected response
   task automatic send_request(op_type op, int unsigned nbytes, int unsigned unit,
                               output logic [UNIT_W-1:0] granted);
      int gap;
      grant_expect_type exp_rsp;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_request_bytes <= BYTES_W'(nbytes);
      req_payload_unit  <= UNIT_W'(unit);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_ALLOC) begin
         exp_rsp.unit = predict_alloc(nbytes);
         exp_rsp.ok   = (exp_rsp.unit != 0);
         n_alloc++;
         if (exp_rsp.ok) n_granted++;
      end else begin
         exp_rsp.unit = '0;
         exp_rsp.ok   = predict_release(unit);
         n_release++;
         if (exp_rsp.ok) n_released++;
      end
      granted = exp_rsp.unit;
      pending_grants.push_back(exp_rsp);
      @(negedge clock);
   endtask

   task automatic alloc_item(int unsigned nbytes, output logic [UNIT_W-1:0] granted);
      send_request(OP_ALLOC, nbytes, $urandom_range(0, 4095), granted);
   endtask

   task automatic free_item(int unsigned unit);
      logic [UNIT_W-1:0] unused;
      send_request(OP_FREE, $urandom_range(0, MAX_BYTES), unit, unused);
   endtask

   // ---------------------------------------------------------------
   // Response side: random ready gaps, plus one long hold-off on request
   // ---------------------------------------------------------------
   initial begin : rsp_sink
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            gap = LONG_HOLD_CYCLES;
            long_holds_done++;
         end else begin
            gap = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      grant_expect_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected response unit=%0d success=%0b",
                     $time, rsp_granted_unit, rsp_success);
            errors++;
         end else begin
            exp_rsp = pending_grants.pop_front();
            n_checked++;
            if (rsp_granted_unit !== exp_rsp.unit) begin
               $display("%0t: granted_unit expected %0d actual %0d",
                        $time, exp_rsp.unit, rsp_granted_unit);
               errors++;
            end
            if (rsp_success !== exp_rsp.ok) begin
               $display("%0t: success expected %0b actual %0b",
                        $time, exp_rsp.ok, rsp_success);
               errors++;
            end
         end
      end
   end

   // Abort when no transfer happens on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, pending_grants.size());
            $display("testbench failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Zero byte count, oversized requests up to the full field, null free
   task automatic test_null_requests();
      logic [UNIT_W-1:0] g;
      alloc_item(0, g);
      alloc_item(MAX_BYTES, g);
      alloc_item(FIELD_MAX_BYTES, g);
      free_item(0);
   endtask

   // Exact fit of the whole arena, then no fit, then release
   task automatic test_whole_arena();
      logic [UNIT_W-1:0] g;
      alloc_item(MAX_BYTES - 32, g);
      alloc_item(1, g);
      free_item(1);
   endtask

   // Plain free, merge with next, exact refit, then two more merges with next
   task automatic test_coalescing();
      logic [UNIT_W-1:0] g;
      alloc_item(16, g);
      alloc_item(32, g);
      alloc_item(48, g);
      free_item(4);
      free_item(1);
      alloc_item(65, g);
      free_item(8);
      free_item(1);
   endtask

   // Blocks at the arena end, remainders of 0, 1 and 2 units, double free
   task automatic test_arena_end();
      logic [UNIT_W-1:0] g;
      alloc_item(65440, g);
      alloc_item(17, g);
      free_item(4093);
      alloc_item(1, g);
      free_item(1);
      alloc_item(65408, g);
      free_item(4093);
      free_item(1);
      free_item(1);
   endtask

   // Mixed traffic with random sizes, frees of live blocks and stray frees
   task automatic test_random_mix(int count);
      int r, k, idx;
      int unsigned nbytes, pu;
      logic [UNIT_W-1:0] g;
      for (int i = 0; i < count; i++) begin
         // alternate stretches with and without idling
         if (i % 200 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (i == count / 2) long_hold_req = 1'b1;
         r = $urandom_range(0, 99);
         if (live_units.size() > 0 && (r < 40 || live_units.size() > 48)) begin
            idx = $urandom_range(0, live_units.size() - 1);
            pu = live_units[idx];
            live_units.delete(idx);
            free_item(pu);
         end else if (r < 44) begin
            free_item(0);
         end else if (r < 47) begin
            // free again a block that is already free
            free_item(pick_free_block());
         end else begin
            k = $urandom_range(0, 99);
            if (k < 3)       nbytes = 0;
            else if (k < 8)  nbytes = $urandom_range(0, FIELD_MAX_BYTES);
            else if (k < 11) nbytes = MAX_BYTES;
            else if (k < 60) nbytes = $urandom_range(1, 128);
            else             nbytes = $urandom_range(1, 1024);
            alloc_item(nbytes, g);
            if (g != 0) live_units.push_back(g);
         end
      end
      idle_on = 1'b1;
   endtask

   // Fill the arena under a long response hold-off, then drain in random order
   task automatic test_fill_and_drain();
      int idx;
      logic [UNIT_W-1:0] g;
      while (live_units.size() > 0) begin
         free_item(live_units.pop_front());
      end
      long_hold_req = 1'b1;
      g = 1;
      while (g != 0) begin
         alloc_item(1000, g);
         if (g != 0) live_units.push_back(g);
      end
      while (live_units.size() > 0) begin
         idx = $urandom_range(0, live_units.size() - 1);
         free_item(live_units[idx]);
         live_units.delete(idx);
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_ALLOC;
      req_request_bytes = '0;
      req_payload_unit  = '0;
      clear_shadow();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_null_requests();
      test_whole_arena();
      test_coalescing();
      test_arena_end();
      test_random_mix(RANDOM_ITEMS);
      test_fill_and_drain();

      // drop valid and let the last responses drain
      req_valid <= 1'b0;
      while (pending_grants.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d allocate items (%0d granted) and %0d free items (%0d performed),",
               n_alloc, n_granted, n_release, n_released);
      $display("%0d responses checked, %0d long response hold-offs, %0d mismatches.",
               n_checked, long_holds_done, errors);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
